>>> src/pce_pkg.sv
`default_nettype none
package pce_pkg;

  // default coordinate storage width
  localparam int COORD_WIDTH_DEF = 32;

  // width of the point fields on the ports
  localparam int FIELD_W = 32;

  // depth of the work queue between front and back
  localparam int QDEPTH = 4;

  // command codes
  localparam logic [2:0] OP_MOVE  = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_CURVE = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  // event codes
  localparam logic [2:0] EV_EDGE   = 3'd0;
  localparam logic [2:0] EV_SPLINE = 3'd1;
  localparam logic [2:0] EV_CAP    = 3'd2;
  localparam logic [2:0] EV_JOIN   = 3'd3;
  localparam logic [2:0] EV_PATH   = 3'd4;

  // one path command
  typedef struct packed {
    logic [2:0]                 operation;
    logic signed [FIELD_W-1:0]  pt_a_x;
    logic signed [FIELD_W-1:0]  pt_a_y;
    logic signed [FIELD_W-1:0]  pt_b_x;
    logic signed [FIELD_W-1:0]  pt_b_y;
    logic signed [FIELD_W-1:0]  pt_c_x;
    logic signed [FIELD_W-1:0]  pt_c_y;
  } cmd_t;

  // one output event
  typedef struct packed {
    logic [2:0]                 event_kind;
    logic signed [FIELD_W-1:0]  from_x;
    logic signed [FIELD_W-1:0]  from_y;
    logic signed [FIELD_W-1:0]  ctrl1_x;
    logic signed [FIELD_W-1:0]  ctrl1_y;
    logic signed [FIELD_W-1:0]  ctrl2_x;
    logic signed [FIELD_W-1:0]  ctrl2_y;
    logic signed [FIELD_W-1:0]  to_x;
    logic signed [FIELD_W-1:0]  to_y;
    logic                       last_of_run;
  } evt_t;

  // classified work handed from front to back
  typedef struct packed {
    evt_t       first;
    logic       two;
    logic [2:0] kind2;
  } work_t;

endpackage
`default_nettype wire

>>> src/pce_front.sv
`default_nettype none
module pce_front #(
  parameter int COORD_WIDTH = pce_pkg::COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire pce_pkg::cmd_t  cmd,
  output logic                push,
  output pce_pkg::work_t      work,
  input  wire logic           full
);

  // stored coordinate width
  localparam int CW = (COORD_WIDTH > pce_pkg::FIELD_W) ? pce_pkg::FIELD_W : COORD_WIDTH;

  logic [CW-1:0] cur_x, cur_y, start_x, start_y;
  logic [CW-1:0] cur_x_next, cur_y_next, start_x_next, start_y_next;
  logic          have_current, have_edge;
  logic          have_current_next, have_edge_next;
  logic          accept;
  logic          has_work;
  logic [CW-1:0] ax, ay, cx, cy;

  assign cmd_stall = full;
  assign accept    = cmd_valid && !full;
  assign push      = accept && has_work;

  // inputs reduced to the stored width
  assign ax = cmd.pt_a_x[CW-1:0];
  assign ay = cmd.pt_a_y[CW-1:0];
  assign cx = cmd.pt_c_x[CW-1:0];
  assign cy = cmd.pt_c_y[CW-1:0];

  // classify the command against the path state
  always_comb begin
    work              = '0;
    has_work          = 1'b0;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    start_x_next      = start_x;
    start_y_next      = start_y;
    have_current_next = have_current;
    have_edge_next    = have_edge;
    case (cmd.operation)
      pce_pkg::OP_MOVE: begin
        if (have_edge) begin
          has_work                     = 1'b1;
          work.first.event_kind        = pce_pkg::EV_CAP;
          work.first.last_of_run       = 1'b1;
        end
        start_x_next      = ax;
        start_y_next      = ay;
        cur_x_next        = ax;
        cur_y_next        = ay;
        have_current_next = 1'b1;
        have_edge_next    = 1'b0;
      end
      pce_pkg::OP_LINE: begin
        if (have_current) begin
          has_work               = 1'b1;
          work.first.event_kind  = pce_pkg::EV_EDGE;
          work.first.from_x      = 32'(cur_x);
          work.first.from_y      = 32'(cur_y);
          work.first.to_x        = 32'(ax);
          work.first.to_y        = 32'(ay);
          work.first.last_of_run = 1'b1;
          cur_x_next             = ax;
          cur_y_next             = ay;
          have_edge_next         = 1'b1;
        end else begin
          start_x_next      = ax;
          start_y_next      = ay;
          cur_x_next        = ax;
          cur_y_next        = ay;
          have_current_next = 1'b1;
          have_edge_next    = 1'b0;
        end
      end
      pce_pkg::OP_CURVE: begin
        if (have_current) begin
          has_work               = 1'b1;
          work.first.event_kind  = pce_pkg::EV_SPLINE;
          work.first.from_x      = 32'(cur_x);
          work.first.from_y      = 32'(cur_y);
          work.first.ctrl1_x     = 32'(ax);
          work.first.ctrl1_y     = 32'(ay);
          work.first.ctrl2_x     = 32'(cmd.pt_b_x[CW-1:0]);
          work.first.ctrl2_y     = 32'(cmd.pt_b_y[CW-1:0]);
          work.first.to_x        = 32'(cx);
          work.first.to_y        = 32'(cy);
          work.first.last_of_run = 1'b1;
          cur_x_next             = cx;
          cur_y_next             = cy;
          have_edge_next         = 1'b1;
        end else begin
          start_x_next      = cx;
          start_y_next      = cy;
          cur_x_next        = cx;
          cur_y_next        = cy;
          have_current_next = 1'b1;
          have_edge_next    = 1'b0;
        end
      end
      pce_pkg::OP_CLOSE: begin
        if (have_edge) begin
          has_work              = 1'b1;
          work.first.event_kind = pce_pkg::EV_EDGE;
          work.first.from_x     = 32'(cur_x);
          work.first.from_y     = 32'(cur_y);
          work.first.to_x       = 32'(start_x);
          work.first.to_y       = 32'(start_y);
          work.two              = 1'b1;
          work.kind2            = pce_pkg::EV_JOIN;
        end
        cur_x_next        = '0;
        cur_y_next        = '0;
        start_x_next      = '0;
        start_y_next      = '0;
        have_current_next = 1'b0;
        have_edge_next    = 1'b0;
      end
      pce_pkg::OP_END: begin
        has_work = 1'b1;
        if (have_edge) begin
          work.first.event_kind = pce_pkg::EV_CAP;
          work.two              = 1'b1;
          work.kind2            = pce_pkg::EV_PATH;
        end else begin
          work.first.event_kind  = pce_pkg::EV_PATH;
          work.first.last_of_run = 1'b1;
        end
        cur_x_next        = '0;
        cur_y_next        = '0;
        start_x_next      = '0;
        start_y_next      = '0;
        have_current_next = 1'b0;
        have_edge_next    = 1'b0;
      end
      default: begin
        has_work = 1'b0;
      end
    endcase
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= '0;
      cur_y        <= '0;
      start_x      <= '0;
      start_y      <= '0;
      have_current <= 1'b0;
      have_edge    <= 1'b0;
    end else if (accept) begin
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      start_x      <= start_x_next;
      start_y      <= start_y_next;
      have_current <= have_current_next;
      have_edge    <= have_edge_next;
    end
  end

endmodule
`default_nettype wire

>>> src/pce_queue.sv
`default_nettype none
module pce_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pce_pkg::work_t  wr_data,
  output logic                 full,
  input  wire logic            pop,
  output pce_pkg::work_t       rd_data,
  output logic                 empty
);

  localparam int PTR_W = (pce_pkg::QDEPTH > 1) ? $clog2(pce_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(pce_pkg::QDEPTH + 1);

  pce_pkg::work_t   entries [pce_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(pce_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pce_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pce_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/pce_back.sv
`default_nettype none
module pce_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pce_pkg::work_t  work,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 evt_valid,
  input  wire logic            evt_stall,
  output pce_pkg::evt_t        evt
);

  logic          load_ok;
  logic          pending;
  logic [2:0]    kind2;
  pce_pkg::evt_t second;

  // output register free or being taken this cycle
  assign load_ok = !evt_valid || !evt_stall;
  assign pop     = load_ok && !pending && !empty;

  // owed second event carries only its kind and closes the run
  always_comb begin
    second             = '0;
    second.event_kind  = kind2;
    second.last_of_run = 1'b1;
  end

  // control: output valid and owed second event
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
      pending   <= 1'b0;
      kind2     <= pce_pkg::EV_JOIN;
    end else if (load_ok) begin
      if (pending) begin
        evt_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (!empty) begin
        evt_valid <= 1'b1;
        pending   <= work.two;
        kind2     <= work.kind2;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (pending) begin
        evt <= second;
      end else if (!empty) begin
        evt <= work.first;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/path_command_to_edge_events.sv
// an accepted command's work is written into the queue, then loaded into the output register
// throughput: one command per cycle while the queue has room and each gives at most one event;
//   close with an edge and end with an edge give two events from one queue entry
// a four-entry work queue absorbs bursts between the classifier and the output stage
// reset (synchronous, active high) empties the queue, drops the output and clears the path state
`default_nettype none
module path_command_to_edge_events #(
  parameter int COORD_WIDTH = pce_pkg::COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire pce_pkg::cmd_t  cmd,
  output logic                evt_valid,
  input  wire logic           evt_stall,
  output pce_pkg::evt_t       evt
);

  logic            push, pop, full, empty;
  pce_pkg::work_t  wr_work, rd_work;

  // classify commands and track the path state
  pce_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .work      (wr_work),
    .full      (full)
  );

  // decoupling queue
  pce_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_work),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_work),
    .empty   (empty)
  );

  // expand work into events
  pce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .work      (rd_work),
    .empty     (empty),
    .pop       (pop),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

endmodule
`default_nettype wire

>>> tb/sv/path_command_to_edge_events_tb.sv
`timescale 1ns / 100ps

import pce_pkg::*;

// tracks path state and the queue of events each accepted command must produce
class path_event_scoreboard;
  localparam int MAX_REPORTS = 10;

  logic signed [FIELD_W-1:0] cur_x, cur_y, start_x, start_y;
  bit have_current, have_edge;
  evt_t pending_events[$];
  int unsigned error_count;

  function new();
    error_count = 0;
    clear_path();
  endfunction

  function void clear_path();
    cur_x = '0;
    cur_y = '0;
    start_x = '0;
    start_y = '0;
    have_current = 1'b0;
    have_edge = 1'b0;
  endfunction

  function void begin_subpath(logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y);
    start_x = x;
    start_y = y;
    cur_x = x;
    cur_y = y;
    have_current = 1'b1;
    have_edge = 1'b0;
  endfunction

  // event with every point field zero
  function evt_t bare_event(logic [2:0] kind, logic last);
    evt_t e;
    e = '0;
    e.event_kind = kind;
    e.last_of_run = last;
    return e;
  endfunction

  // accepted command transaction: queue its events and advance the path state
  function void note_command(cmd_t c);
    evt_t e;
    case (c.operation)
      OP_MOVE: begin
        if (have_edge) pending_events.push_back(bare_event(EV_CAP, 1'b1));
        begin_subpath(c.pt_a_x, c.pt_a_y);
      end
      OP_LINE: begin
        if (have_current) begin
          e = bare_event(EV_EDGE, 1'b1);
          e.from_x = cur_x;
          e.from_y = cur_y;
          e.to_x = c.pt_a_x;
          e.to_y = c.pt_a_y;
          pending_events.push_back(e);
          cur_x = c.pt_a_x;
          cur_y = c.pt_a_y;
          have_edge = 1'b1;
        end else begin
          begin_subpath(c.pt_a_x, c.pt_a_y);
        end
      end
      OP_CURVE: begin
        if (have_current) begin
          e = bare_event(EV_SPLINE, 1'b1);
          e.from_x = cur_x;
          e.from_y = cur_y;
          e.ctrl1_x = c.pt_a_x;
          e.ctrl1_y = c.pt_a_y;
          e.ctrl2_x = c.pt_b_x;
          e.ctrl2_y = c.pt_b_y;
          e.to_x = c.pt_c_x;
          e.to_y = c.pt_c_y;
          pending_events.push_back(e);
          cur_x = c.pt_c_x;
          cur_y = c.pt_c_y;
          have_edge = 1'b1;
        end else begin
          begin_subpath(c.pt_c_x, c.pt_c_y);
        end
      end
      OP_CLOSE: begin
        if (have_edge) begin
          e = bare_event(EV_EDGE, 1'b0);
          e.from_x = cur_x;
          e.from_y = cur_y;
          e.to_x = start_x;
          e.to_y = start_y;
          pending_events.push_back(e);
          pending_events.push_back(bare_event(EV_JOIN, 1'b1));
        end
        clear_path();
      end
      OP_END: begin
        if (have_edge) pending_events.push_back(bare_event(EV_CAP, 1'b0));
        pending_events.push_back(bare_event(EV_PATH, 1'b1));
        clear_path();
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endfunction

  // accepted event transaction: compare against the oldest expectation
  function void check_event(evt_t got);
    evt_t want;
    if (pending_events.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: unexpected event, kind %0d", $time, got.event_kind);
      return;
    end
    want = pending_events.pop_front();
    compare_field("event_kind", want.event_kind, got.event_kind);
    compare_field("from_x", want.from_x, got.from_x);
    compare_field("from_y", want.from_y, got.from_y);
    compare_field("ctrl1_x", want.ctrl1_x, got.ctrl1_x);
    compare_field("ctrl1_y", want.ctrl1_y, got.ctrl1_y);
    compare_field("ctrl2_x", want.ctrl2_x, got.ctrl2_x);
    compare_field("ctrl2_y", want.ctrl2_y, got.ctrl2_y);
    compare_field("to_x", want.to_x, got.to_x);
    compare_field("to_y", want.to_y, got.to_y);
    compare_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module path_command_to_edge_events_tb;
  localparam int COMMAND_TARGET = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_ALTERNATE} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic evt_valid;
  logic evt_stall = 1'b0;
  evt_t evt;

  path_event_scoreboard sb = new();
  int commands_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  path_command_to_edge_events dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // coordinates weighted toward extremes and small values
  function automatic logic signed [FIELD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return '1;
      4, 5: return ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t random_cmd(logic [2:0] op);
    cmd_t c;
    c.operation = op;
    c.pt_a_x = random_coord();
    c.pt_a_y = random_coord();
    c.pt_b_x = random_coord();
    c.pt_b_y = random_coord();
    c.pt_c_x = random_coord();
    c.pt_c_y = random_coord();
    return c;
  endfunction

  // drive one command until accepted, then pace the sender in bursts
  task automatic send_cmd(input cmd_t c);
    int gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
    if (c.operation <= OP_END) commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // well-formed path: subpaths of lines and curves, some closed, mostly ended
  task automatic send_path();
    int subpaths;
    int segments;
    subpaths = $urandom_range(1, 3);
    repeat (subpaths) begin
      if ($urandom_range(0, 4) != 0) send_cmd(random_cmd(OP_MOVE));
      segments = $urandom_range(0, 6);
      repeat (segments) send_cmd(random_cmd($urandom_range(0, 1) ? OP_CURVE : OP_LINE));
      if ($urandom_range(0, 2) == 0) send_cmd(random_cmd(OP_CLOSE));
    end
    if ($urandom_range(0, 5) != 0) send_cmd(random_cmd(OP_END));
  endtask

  // receiver stall pattern, switching to a random mode whenever its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: evt_stall <= 1'b0;
      STALL_RANDOM: evt_stall <= ($urandom_range(0, 2) == 0);
      STALL_LONG: evt_stall <= (stall_left[3:0] < 4'd10);
      default: evt_stall <= stall_left[0];
    endcase
  end

  // event monitor
  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) sb.check_event(evt);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (evt_valid && !evt_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t c;
    logic [2:0] odd_op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // close and end on an empty path
    send_cmd(random_cmd(OP_CLOSE));
    send_cmd(random_cmd(OP_END));
    // line with no current point only starts a subpath
    c = random_cmd(OP_LINE);
    c.pt_a_x = COORD_MAX;
    c.pt_a_y = COORD_MIN;
    send_cmd(c);
    c = random_cmd(OP_LINE);
    c.pt_a_x = COORD_MIN;
    c.pt_a_y = COORD_MAX;
    send_cmd(c);
    c = random_cmd(OP_CURVE);
    c.pt_a_x = COORD_MAX;
    c.pt_a_y = COORD_MAX;
    c.pt_b_x = COORD_MIN;
    c.pt_b_y = COORD_MIN;
    c.pt_c_x = '0;
    c.pt_c_y = '1;
    send_cmd(c);
    // move after an edge caps, a second move does not
    send_cmd(random_cmd(OP_MOVE));
    send_cmd(random_cmd(OP_MOVE));
    // unknown codes leave the state alone
    odd_op = OP_END;
    repeat (3) begin
      odd_op++;
      send_cmd(random_cmd(odd_op));
    end
    send_cmd(random_cmd(OP_LINE));
    send_cmd(random_cmd(OP_CURVE));
    // close with an edge gives edge plus join
    send_cmd(random_cmd(OP_CLOSE));
    // curve with no current point starts at its end point
    send_cmd(random_cmd(OP_CURVE));
    send_cmd(random_cmd(OP_LINE));
    // end with an edge gives cap plus path done
    send_cmd(random_cmd(OP_END));
    // close right after a move has no edge
    send_cmd(random_cmd(OP_MOVE));
    send_cmd(random_cmd(OP_CLOSE));
    send_cmd(random_cmd(OP_LINE));
    send_cmd(random_cmd(OP_END));

    // random paths with some noise mixed in
    while (commands_sent < COMMAND_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        send_path();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          odd_op = 3'($urandom);
          send_cmd(random_cmd(odd_op));
        end
      end
    end
    cmd_valid <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_events.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
